// ----- design/cosp_pkg.sv -----
// ----------------------------------------------------------------------------
// CoAP option stream parser package
// Parser phases, result kinds, error causes and field widths.
// ----------------------------------------------------------------------------
package cosp_pkg;

  localparam int unsigned PhaseW = 3;
  localparam int unsigned KindW  = 3;
  localparam int unsigned CauseW = 3;
  localparam int unsigned NumW   = 16;
  localparam int unsigned AccW   = 17;
  localparam int unsigned LenW   = 11;

  localparam logic [PhaseW-1:0] PH_HDR     = 3'd0;
  localparam logic [PhaseW-1:0] PH_DEXT_A  = 3'd1;
  localparam logic [PhaseW-1:0] PH_DEXT_B  = 3'd2;
  localparam logic [PhaseW-1:0] PH_LEXT_A  = 3'd3;
  localparam logic [PhaseW-1:0] PH_LEXT_B  = 3'd4;
  localparam logic [PhaseW-1:0] PH_VALUE   = 3'd5;
  localparam logic [PhaseW-1:0] PH_PAYLOAD = 3'd6;
  localparam logic [PhaseW-1:0] PH_IDLE    = 3'd7;

  localparam logic [KindW-1:0] KIND_HEADER  = 3'd0;
  localparam logic [KindW-1:0] KIND_VALUE   = 3'd1;
  localparam logic [KindW-1:0] KIND_MARKER  = 3'd2;
  localparam logic [KindW-1:0] KIND_PAYLOAD = 3'd3;
  localparam logic [KindW-1:0] KIND_ERROR   = 3'd4;

  localparam logic [CauseW-1:0] ERR_NONE     = 3'd0;
  localparam logic [CauseW-1:0] ERR_PAST_END = 3'd1;
  localparam logic [CauseW-1:0] ERR_HDR_CUT  = 3'd2;
  localparam logic [CauseW-1:0] ERR_OVERFLOW = 3'd3;
  localparam logic [CauseW-1:0] ERR_RESERVED = 3'd4;

  localparam logic [3:0] NIB_EXT8     = 4'd13;
  localparam logic [3:0] NIB_EXT16    = 4'd14;
  localparam logic [3:0] NIB_RESERVED = 4'd15;

  localparam logic [AccW-1:0] EXT8_BASE  = 17'd13;
  localparam logic [AccW-1:0] EXT16_BASE = 17'd269;

endpackage

// ----- design/coap_option_stream_parser.sv -----
// ----------------------------------------------------------------------------
// CoAP option stream parser
// Decodes option headers byte by byte, tracks the option number, passes
// value and payload bytes through and reports malformed headers.
// ----------------------------------------------------------------------------
// Each accepted item is held in the input register, then in the result register.
// Throughput: one item per cycle while out_tready does not stall the output; decode
// sits between the input register and the result register, and the parse state
// updates as each item leaves the input register. Bytes inside an extended header give no result.
// Reset: rst_n is synchronous and active low; it empties both registers,
// sets the parser to wait for a header and clears target_option.
// ----------------------------------------------------------------------------
module coap_option_stream_parser
  import cosp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // target_option
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // data_byte[7:0], bytes_after[18:8], zeros
  input  logic        in_tuser,      // start_of_options
  output logic        out_tvalid,
  input  logic        out_tready,
  // option_number[15:0], number_delta[32:16], value_length[43:33],
  // out_byte[51:44], error_cause[54:52], zeros
  output logic [55:0] out_tdata,
  output logic [3:0]  out_tuser,     // kind[2:0], is_target[3]
  output logic        out_tlast      // packet_end
);

  logic [NumW-1:0] target_r;

  logic            in_v_r;
  logic [7:0]      byte_r;
  logic            start_r;
  logic [LenW-1:0] after_r;

  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [3:0]        dnib_r, dnib_nxt;
  logic [3:0]        lnib_r, lnib_nxt;
  logic [AccW-1:0]   dacc_r, dacc_nxt;
  logic [AccW-1:0]   lacc_r, lacc_nxt;
  logic [NumW-1:0]   rnum_r, rnum_nxt;
  logic [LenW-1:0]   vleft_r, vleft_nxt;
  logic [LenW-1:0]   clen_r, clen_nxt;

  logic              out_v_r;
  logic [KindW-1:0]  kind_r, kind_nxt;
  logic [NumW-1:0]   onum_r, onum_nxt;
  logic [AccW-1:0]   odelta_r, odelta_nxt;
  logic [LenW-1:0]   olen_r, olen_nxt;
  logic [7:0]        obyte_r, obyte_nxt;
  logic              otgt_r, otgt_nxt;
  logic [CauseW-1:0] ocause_r, ocause_nxt;
  logic              olast_r;

  logic              res_v;
  logic              advance;
  logic              last;
  logic              go_after_delta;
  logic              go_complete;
  logic              go_more;
  logic [PhaseW-1:0] more_phase;
  logic [NumW+1:0]   sum;

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;
  assign last      = (after_r == '0);

  always_comb begin
    phase_nxt  = start_r ? PH_HDR : phase_r;
    dnib_nxt   = start_r ? '0 : dnib_r;
    lnib_nxt   = start_r ? '0 : lnib_r;
    dacc_nxt   = start_r ? '0 : dacc_r;
    lacc_nxt   = start_r ? '0 : lacc_r;
    rnum_nxt   = start_r ? '0 : rnum_r;
    vleft_nxt  = start_r ? '0 : vleft_r;
    clen_nxt   = start_r ? '0 : clen_r;
    res_v      = 1'b0;
    kind_nxt   = KIND_HEADER;
    onum_nxt   = '0;
    odelta_nxt = '0;
    olen_nxt   = '0;
    obyte_nxt  = '0;
    otgt_nxt   = 1'b0;
    ocause_nxt = ERR_NONE;
    go_after_delta = 1'b0;
    go_complete    = 1'b0;
    go_more        = 1'b0;
    more_phase     = PH_HDR;
    sum            = '0;

    unique case (phase_nxt)
      PH_HDR: begin
        if (byte_r[7:4] == 4'hF) begin
          rnum_nxt  = '0;
          clen_nxt  = after_r;
          res_v     = 1'b1;
          kind_nxt  = KIND_MARKER;
          olen_nxt  = after_r;
          phase_nxt = last ? PH_IDLE : PH_PAYLOAD;
        end else begin
          dnib_nxt = byte_r[7:4];
          lnib_nxt = byte_r[3:0];
          if (byte_r[3:0] == NIB_RESERVED) begin
            res_v      = 1'b1;
            kind_nxt   = KIND_ERROR;
            onum_nxt   = rnum_nxt;
            ocause_nxt = ERR_RESERVED;
            phase_nxt  = PH_IDLE;
          end else begin
            dacc_nxt = {13'd0, byte_r[7:4]};
            lacc_nxt = {13'd0, byte_r[3:0]};
            if (byte_r[7:4] >= NIB_EXT8) begin
              go_more    = 1'b1;
              more_phase = PH_DEXT_A;
            end else begin
              go_after_delta = 1'b1;
            end
          end
        end
      end
      PH_DEXT_A: begin
        if (dnib_nxt == NIB_EXT8) begin
          dacc_nxt       = EXT8_BASE + {9'd0, byte_r};
          go_after_delta = 1'b1;
        end else begin
          dacc_nxt   = EXT16_BASE + {1'b0, byte_r, 8'd0};
          go_more    = 1'b1;
          more_phase = PH_DEXT_B;
        end
      end
      PH_DEXT_B: begin
        dacc_nxt       = dacc_nxt + {9'd0, byte_r};
        go_after_delta = 1'b1;
      end
      PH_LEXT_A: begin
        if (lnib_nxt == NIB_EXT8) begin
          lacc_nxt    = EXT8_BASE + {9'd0, byte_r};
          go_complete = 1'b1;
        end else begin
          lacc_nxt   = EXT16_BASE + {1'b0, byte_r, 8'd0};
          go_more    = 1'b1;
          more_phase = PH_LEXT_B;
        end
      end
      PH_LEXT_B: begin
        lacc_nxt    = lacc_nxt + {9'd0, byte_r};
        go_complete = 1'b1;
      end
      PH_VALUE: begin
        res_v     = 1'b1;
        kind_nxt  = KIND_VALUE;
        onum_nxt  = rnum_nxt;
        olen_nxt  = clen_nxt;
        obyte_nxt = byte_r;
        otgt_nxt  = (target_r != '0) && (rnum_nxt == target_r);
        if (vleft_nxt != '0) begin
          vleft_nxt = vleft_nxt - LenW'(1);
        end
        if (last) begin
          phase_nxt = PH_IDLE;
        end else if (vleft_nxt == '0) begin
          phase_nxt = PH_HDR;
        end
      end
      PH_PAYLOAD: begin
        res_v     = 1'b1;
        kind_nxt  = KIND_PAYLOAD;
        olen_nxt  = clen_nxt;
        obyte_nxt = byte_r;
        if (last) begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_IDLE: begin
        res_v = 1'b0;
      end
      default: begin
        res_v = 1'b0;
      end
    endcase

    if (go_after_delta) begin
      if (lnib_nxt >= NIB_EXT8) begin
        go_more    = 1'b1;
        more_phase = PH_LEXT_A;
      end else begin
        go_complete = 1'b1;
      end
    end

    if (go_more) begin
      if (last) begin
        res_v      = 1'b1;
        kind_nxt   = KIND_ERROR;
        onum_nxt   = rnum_nxt;
        ocause_nxt = ERR_HDR_CUT;
        phase_nxt  = PH_IDLE;
      end else begin
        phase_nxt = more_phase;
      end
    end

    if (go_complete) begin
      sum   = {2'd0, rnum_nxt} + {1'b0, dacc_nxt};
      res_v = 1'b1;
      if (lacc_nxt > {6'd0, after_r}) begin
        kind_nxt   = KIND_ERROR;
        onum_nxt   = rnum_nxt;
        ocause_nxt = ERR_PAST_END;
        phase_nxt  = PH_IDLE;
      end else if (sum[NumW+1:NumW] != 2'd0) begin
        kind_nxt   = KIND_ERROR;
        onum_nxt   = rnum_nxt;
        ocause_nxt = ERR_OVERFLOW;
        phase_nxt  = PH_IDLE;
      end else begin
        rnum_nxt   = sum[NumW-1:0];
        clen_nxt   = lacc_nxt[LenW-1:0];
        vleft_nxt  = lacc_nxt[LenW-1:0];
        kind_nxt   = KIND_HEADER;
        onum_nxt   = sum[NumW-1:0];
        odelta_nxt = dacc_nxt;
        olen_nxt   = lacc_nxt[LenW-1:0];
        otgt_nxt   = (target_r != '0) && (sum[NumW-1:0] == target_r);
        if (last) begin
          phase_nxt = PH_IDLE;
        end else begin
          phase_nxt = (lacc_nxt[LenW-1:0] != '0) ? PH_VALUE : PH_HDR;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      in_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      phase_r  <= PH_HDR;
      dnib_r   <= '0;
      lnib_r   <= '0;
      dacc_r   <= '0;
      lacc_r   <= '0;
      rnum_r   <= '0;
      vleft_r  <= '0;
      clen_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        target_r <= cfg_wr_data;
      end
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (advance) begin
        out_v_r <= res_v;
        phase_r <= phase_nxt;
        dnib_r  <= dnib_nxt;
        lnib_r  <= lnib_nxt;
        dacc_r  <= dacc_nxt;
        lacc_r  <= lacc_nxt;
        rnum_r  <= rnum_nxt;
        vleft_r <= vleft_nxt;
        clen_r  <= clen_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r  <= in_tdata[7:0];
      after_r <= in_tdata[18:8];
      start_r <= in_tuser;
    end
    if (advance && res_v) begin
      kind_r   <= kind_nxt;
      onum_r   <= onum_nxt;
      odelta_r <= odelta_nxt;
      olen_r   <= olen_nxt;
      obyte_r  <= obyte_nxt;
      otgt_r   <= otgt_nxt;
      ocause_r <= ocause_nxt;
      olast_r  <= last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, ocause_r, obyte_r, olen_r, odelta_r, onum_r};
  assign out_tuser  = {otgt_r, kind_r};
  assign out_tlast  = olast_r;

endmodule
